// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the default clk_i / rst_ni pair
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/swa_pkg.sv
`timescale 1ns / 1ps

package swa_pkg;

  localparam int BOX_W          = 16;
  localparam int EDGE_W         = 17;
  localparam int LIMIT_W        = 5;
  localparam int MAX_WINDOW_DEF = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd7;

  typedef struct packed {
    logic [EDGE_W-1:0] bottom;
    logic [EDGE_W-1:0] right;
    logic [BOX_W-1:0]  top;
    logic [BOX_W-1:0]  left;
  } ring_entry_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// File: design/swa_ring.sv
`timescale 1ns / 1ps

module swa_ring import swa_pkg::*; #(
  parameter int DEPTH = MAX_WINDOW_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ring_entry_t   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output ring_entry_t   rdata_o
);

  ring_entry_t mem [DEPTH];
  ring_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/swa_div.sv
`timescale 1ns / 1ps

module swa_div import swa_pkg::*; #(
  parameter int SW = EDGE_W + 5,
  parameter int CW = 6
) (
  input  logic          clk_i,
  input  div_ctrl_t     ctrl_i,
  input  logic [SW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic [SW-1:0] quot_o
);

  logic [CW-1:0] rem_q, rem_d;
  logic [SW-1:0] dq_q, dq_d;
  logic [CW-1:0] dvs_q;
  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  // one quotient bit per cycle while step is set, restoring
  always_comb begin
    trial = {rem_q, dq_q[SW-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
    dq_d  = {dq_q[SW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign quot_o = dq_q;

endmodule

// File: design/sliding_window_box_averager.sv
`timescale 1ns / 1ps
// sliding window box averager
// input stream s_axis carries one box per transfer (left, top, width, height);
// output stream m_axis carries one averaged box per input box.
// config: cfg_we_i writes window_limit from cfg_wdata_i; the user must write it
// only while idle, the block itself does not enforce this. the window keeps
// window_limit + 1 boxes (at most MAX_WINDOW) and then replaces the oldest one.
// each box passes through the ring read, the sum update and ring write, the four
// bit-serial dividers (SW = 17 + log2(MAX_WINDOW) quotient bits) and the output
// register load before the next input transfer can be taken.
// the output register parts the two sides: a new box is taken while the last
// result waits; a stalled receiver holds the finished result in the divider
// until the output register frees up, and input stops meanwhile.
// reset empties the window, clears the sums and sets window_limit to 7;
// no clearing pass is needed, the ring is only read where it was written.
module sliding_window_box_averager import swa_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // box_left, box_top, box_width, box_height
  input  logic [63:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // avg_left, avg_top, avg_width, avg_height
  output logic [63:0]        m_axis_tdata
);

`include "assert_macros.svh"

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = EDGE_W + AW;
  localparam int LSW   = SW - 1;
  localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int DCW   = $clog2(SW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_DIV, ST_OUT} state_e;

  state_e             state_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [AW-1:0]      oldest_q;
  logic [CW-1:0]      count_q;
  logic [LSW-1:0]     lsum_q, tsum_q, lsum_d, tsum_d;
  logic [SW-1:0]      rsum_q, bsum_q, rsum_d, bsum_d;
  logic [BOX_W-1:0]   l_q, t_q;
  logic [EDGE_W-1:0]  r_q, b_q;
  logic               replace_q;
  logic [AW-1:0]      waddr_q;
  logic [DCW-1:0]     div_cnt_q;
  logic               m_tvalid_q;
  logic [63:0]        m_tdata_q;

  logic               s_xfer;
  logic               full;
  logic [AW:0]        grow_addr;
  logic [AW-1:0]      waddr_d;
  logic [CW-1:0]      count_d;
  logic [AW-1:0]      oldest_d;
  logic               out_free;
  ring_entry_t        rd_entry;
  ring_entry_t        wr_entry;
  div_ctrl_t          div_ctrl;
  logic [SW-1:0]      ql, qt, qr, qb;
  logic [EDGE_W-1:0]  avg_w, avg_h;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  always_comb begin
    full = (CMP_W'(count_q) > CMP_W'(limit_q)) || (count_q == CW'(MAX_WINDOW));
    grow_addr = {1'b0, oldest_q} + (AW + 1)'(count_q);
    if (grow_addr >= (AW + 1)'(MAX_WINDOW)) begin
      grow_addr = grow_addr - (AW + 1)'(MAX_WINDOW);
    end
    waddr_d = full ? oldest_q : grow_addr[AW-1:0];
  end

  // sum update with the new box and the box that leaves the window
  always_comb begin
    lsum_d   = lsum_q + LSW'(l_q) - (replace_q ? LSW'(rd_entry.left) : '0);
    tsum_d   = tsum_q + LSW'(t_q) - (replace_q ? LSW'(rd_entry.top) : '0);
    rsum_d   = rsum_q + SW'(r_q) - (replace_q ? SW'(rd_entry.right) : '0);
    bsum_d   = bsum_q + SW'(b_q) - (replace_q ? SW'(rd_entry.bottom) : '0);
    count_d  = replace_q ? count_q : count_q + CW'(1);
    oldest_d = oldest_q;
    if (replace_q) begin
      oldest_d = (oldest_q == AW'(MAX_WINDOW - 1)) ? '0 : oldest_q + AW'(1);
    end
    wr_entry.left   = l_q;
    wr_entry.top    = t_q;
    wr_entry.right  = r_q;
    wr_entry.bottom = b_q;
    div_ctrl.load   = (state_q == ST_UPD);
    div_ctrl.step   = (state_q == ST_DIV);
  end

  swa_ring #(.DEPTH(MAX_WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (waddr_q),
    .wdata_i (wr_entry),
    .re_i    (s_xfer),
    .raddr_i (oldest_q),
    .rdata_o (rd_entry)
  );

  swa_div #(.SW(SW), .CW(CW)) u_div_left (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .dividend_i (SW'(lsum_d)),
    .divisor_i (count_d), .quot_o (ql)
  );

  swa_div #(.SW(SW), .CW(CW)) u_div_top (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .dividend_i (SW'(tsum_d)),
    .divisor_i (count_d), .quot_o (qt)
  );

  swa_div #(.SW(SW), .CW(CW)) u_div_right (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .dividend_i (rsum_d),
    .divisor_i (count_d), .quot_o (qr)
  );

  swa_div #(.SW(SW), .CW(CW)) u_div_bottom (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .dividend_i (bsum_d),
    .divisor_i (count_d), .quot_o (qb)
  );

  assign avg_w = qr[EDGE_W-1:0] - ql[EDGE_W-1:0];
  assign avg_h = qb[EDGE_W-1:0] - qt[EDGE_W-1:0];

  // input payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      l_q       <= s_axis_tdata[15:0];
      t_q       <= s_axis_tdata[31:16];
      r_q       <= EDGE_W'(s_axis_tdata[15:0]) + EDGE_W'(s_axis_tdata[47:32]);
      b_q       <= EDGE_W'(s_axis_tdata[31:16]) + EDGE_W'(s_axis_tdata[63:48]);
      replace_q <= full;
      waddr_q   <= waddr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      limit_q    <= LIMIT_RST;
      oldest_q   <= '0;
      count_q    <= '0;
      lsum_q     <= '0;
      tsum_q     <= '0;
      rsum_q     <= '0;
      bsum_q     <= '0;
      div_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (m_tvalid_q && m_axis_tready && state_q != ST_OUT) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          lsum_q    <= lsum_d;
          tsum_q    <= tsum_d;
          rsum_q    <= rsum_d;
          bsum_q    <= bsum_d;
          count_q   <= count_d;
          oldest_q  <= oldest_d;
          div_cnt_q <= DCW'(SW);
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q - DCW'(1);
          if (div_cnt_q == DCW'(1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {avg_h[BOX_W-1:0], avg_w[BOX_W-1:0],
                           qt[BOX_W-1:0], ql[BOX_W-1:0]};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `ASSERT_DEF(a_count_bound, count_q <= CW'(MAX_WINDOW), "box count above window size")
  `ASSERT_DEF(a_div_nonzero, (state_q == ST_DIV) |-> (count_q != '0), "divide by empty window")
  `ASSERT_DEF(a_oldest_range, oldest_q < AW'(MAX_WINDOW - 1) || oldest_q == AW'(MAX_WINDOW - 1), "oldest slot beyond ring")

endmodule

// File: tb/sv/sliding_window_box_averager_tb.sv
`timescale 1ns / 1ps

module sliding_window_box_averager_tb;
  import swa_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW_DEF;

  typedef struct packed {
    logic [BOX_W-1:0] height;
    logic [BOX_W-1:0] width;
    logic [BOX_W-1:0] top;
    logic [BOX_W-1:0] left;
  } box_t;

  class avg_box_scoreboard;
    logic [BOX_W-1:0]   left_ring [RING_DEPTH];
    logic [BOX_W-1:0]   top_ring [RING_DEPTH];
    logic [EDGE_W-1:0]  right_ring [RING_DEPTH];
    logic [EDGE_W-1:0]  bottom_ring [RING_DEPTH];
    int unsigned        oldest;
    int unsigned        count;
    logic [20:0]        left_sum;
    logic [20:0]        top_sum;
    logic [21:0]        right_sum;
    logic [21:0]        bottom_sum;
    logic [LIMIT_W-1:0] limit;
    box_t               expected_avgs[$];
    int unsigned        errors;

    function new();
      oldest     = 0;
      count      = 0;
      left_sum   = '0;
      top_sum    = '0;
      right_sum  = '0;
      bottom_sum = '0;
      limit      = LIMIT_RST;
      errors     = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    // push the box into the window and queue the averaged box
    function void note_box(box_t b);
      logic [EDGE_W-1:0] r;
      logic [EDGE_W-1:0] bt;
      int unsigned       slot;
      logic [BOX_W-1:0]  al;
      logic [BOX_W-1:0]  at;
      logic [EDGE_W-1:0] ar;
      logic [EDGE_W-1:0] ab;
      box_t              e;
      r  = {1'b0, b.left} + {1'b0, b.width};
      bt = {1'b0, b.top} + {1'b0, b.height};
      if (count > limit || count >= RING_DEPTH) begin
        slot       = oldest % RING_DEPTH;
        left_sum   = left_sum - left_ring[slot] + b.left;
        top_sum    = top_sum - top_ring[slot] + b.top;
        right_sum  = right_sum - right_ring[slot] + r;
        bottom_sum = bottom_sum - bottom_ring[slot] + bt;
        oldest     = (slot + 1) % RING_DEPTH;
      end else begin
        slot       = (oldest + count) % RING_DEPTH;
        left_sum   = left_sum + b.left;
        top_sum    = top_sum + b.top;
        right_sum  = right_sum + r;
        bottom_sum = bottom_sum + bt;
        count++;
      end
      left_ring[slot]   = b.left;
      top_ring[slot]    = b.top;
      right_ring[slot]  = r;
      bottom_ring[slot] = bt;
      al = BOX_W'(left_sum / count);
      at = BOX_W'(top_sum / count);
      ar = EDGE_W'(right_sum / count);
      ab = EDGE_W'(bottom_sum / count);
      e.left   = al;
      e.top    = at;
      e.width  = BOX_W'(ar - EDGE_W'(al));
      e.height = BOX_W'(ab - EDGE_W'(at));
      expected_avgs.push_back(e);
    endfunction

    function void check_avg(logic [63:0] d);
      box_t e;
      box_t a;
      if (expected_avgs.size() == 0) begin
        $error("unexpected result transfer: %h", d);
        errors++;
        return;
      end
      e = expected_avgs.pop_front();
      a = d;
      if (a.left !== e.left) begin
        $error("avg_left mismatch: expected %0d, actual %0d", e.left, a.left);
        errors++;
      end
      if (a.top !== e.top) begin
        $error("avg_top mismatch: expected %0d, actual %0d", e.top, a.top);
        errors++;
      end
      if (a.width !== e.width) begin
        $error("avg_width mismatch: expected %0d, actual %0d", e.width, a.width);
        errors++;
      end
      if (a.height !== e.height) begin
        $error("avg_height mismatch: expected %0d, actual %0d", e.height, a.height);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_avgs.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // box_left, box_top, box_width, box_height
  logic [63:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // avg_left, avg_top, avg_width, avg_height
  logic [63:0]        m_axis_tdata;

  avg_box_scoreboard sb;
  bit                idle_on;
  int unsigned       boxes_sent;

  sliding_window_box_averager u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 12) : 0;
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_box(box_t b);
    int unsigned gap;
    bit          taken;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do begin
      @(posedge clk_i);
      taken = s_axis_tready;
      if (taken) sb.note_box(b);
      @(negedge clk_i);
    end while (!taken);
    boxes_sent++;
  endtask

  task automatic send_fields(logic [15:0] l, logic [15:0] t, logic [15:0] w,
                             logic [15:0] h);
    box_t b;
    b.left   = l;
    b.top    = t;
    b.width  = w;
    b.height = h;
    send_box(b);
  endtask

  // window_limit is written only once every result is out
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_limit(v);
  endtask

  function automatic box_t random_box();
    box_t b;
    b = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: b = '1;
      1: b = '0;
      2: begin
        b.left = 16'hffff;
        b.top  = 16'hffff;
      end
      3: begin
        b.width  = 16'hffff;
        b.height = 16'hffff;
      end
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_avg(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    sb            = new();
    idle_on       = 1'b1;
    boxes_sent    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default limit: extremes, then overrun the window of eight
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h0000, 16'hffff, 16'hffff, 16'h0000);
    send_fields(16'hffff, 16'h0000, 16'h0000, 16'hffff);
    send_fields(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    repeat (6) send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h0001, 16'h8000, 16'h0001, 16'h8000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // single-box window
    write_limit(5'd0);
    send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h0000, 16'h0000, 16'hffff, 16'hffff);
    send_fields(16'h1234, 16'h8765, 16'h4321, 16'h789a);

    // largest window, filled past the ring depth
    write_limit(5'd31);
    idle_on = 1'b0;
    repeat (40) send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    repeat (4) send_box(random_box());

    // limit lowered while the window is full: size stays
    write_limit(5'd2);
    idle_on = 1'b1;
    repeat (10) send_box(random_box());

    while (boxes_sent < 470) begin
      case ($urandom_range(0, 4))
        0: write_limit(5'd0);
        1: write_limit(5'd31);
        2: ;
        default: write_limit(LIMIT_W'($urandom_range(0, 31)));
      endcase
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(5, 60);
      repeat (phase_len) send_box(random_box());
    end

    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
